/* sv/positional_list_store_macros.svh */
// Assertion macros shared by the positional list store RTL.
`ifndef POSITIONAL_LIST_STORE_MACROS_SVH
`define POSITIONAL_LIST_STORE_MACROS_SVH
`ifndef SYNTHESIS
// Condition a implies condition b in the same cycle.
`define PLS_ASSERT_NOW(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("positional_list_store: assertion failed");
// Condition a implies condition b in the next cycle.
`define PLS_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("positional_list_store: assertion failed");
`else
`define PLS_ASSERT_NOW(label, clk, rst_n, a, b)
`define PLS_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

/* sv/plstore_pkg.sv */
// Shared types and constants of the positional list store.
package plstore_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = 7;
    localparam int POS_W    = 7;
    localparam int DATA_W   = 32;

    localparam logic [2:0] OP_READ       = 3'd0;
    localparam logic [2:0] OP_INS_AFTER  = 3'd1;
    localparam logic [2:0] OP_INS_BEFORE = 3'd2;
    localparam logic [2:0] OP_DELETE     = 3'd3;
    localparam logic [2:0] OP_CHANGE     = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_POS   = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    // Command broadcast to every cell of the row
    typedef struct packed {
        logic              ins;
        logic              del;
        logic              wr;
        logic [IDX_W-1:0]  sel;
        logic [DATA_W-1:0] data;
    } cell_cmd_t;

endpackage

/* sv/plstore_cell.sv */
// One storage cell of the list row: holds an element and shifts with its neighbours.
module plstore_cell
(
    input  logic                                clk,
    input  plstore_pkg::cell_cmd_t              cmd,
    input  logic [plstore_pkg::IDX_W-1:0]       idx,
    input  logic [plstore_pkg::DATA_W-1:0]      left_q,
    input  logic [plstore_pkg::DATA_W-1:0]      right_q,
    output logic [plstore_pkg::DATA_W-1:0]      q,
    output logic [plstore_pkg::DATA_W-1:0]      rd
);

    logic [plstore_pkg::DATA_W-1:0] q_reg;
    logic [plstore_pkg::DATA_W-1:0] q_next;
    logic                           hit;

    assign hit = (idx == cmd.sel);

    always_comb
    begin
        q_next = q_reg;
        if (cmd.ins)
        begin
            // open a gap: cells past the slot take the left neighbour
            if (idx > cmd.sel)
                q_next = left_q;
            else if (hit)
                q_next = cmd.data;
        end
        else if (cmd.del)
        begin
            // close the gap from the right
            if (idx >= cmd.sel)
                q_next = right_q;
        end
        else if (cmd.wr && hit)
        begin
            q_next = cmd.data;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q  = q_reg;
    assign rd = hit ? q_reg : '0;

endmodule

/* sv/positional_list_store.sv */
// Positional list store: dense ordered list of signed values held in a row of cells.
// Each accepted item is held in the decode stage, then registered in the output register.
// Throughput: one item per cycle while the output is not stalled; the cell row shifts all elements together.
// Output register stalls the row only while a result waits and the next one is done.
// Reset: asynchronous, clears the element count and all valid flags; list is empty.
// Element contents are undefined after reset and never read before they are written.
`include "positional_list_store_macros.svh"
module positional_list_store
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] operation, [9:3] position, [41:10] data_value, [47:42] zero
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] result_value, [33:32] status, [40:34] list_length, [47:41] zero
    output logic [47:0] m_axis_tdata
);

    localparam int CAP   = plstore_pkg::CAPACITY;
    localparam int IDX_W = plstore_pkg::IDX_W;
    localparam int CNT_W = plstore_pkg::CNT_W;
    localparam int POS_W = plstore_pkg::POS_W;
    localparam int DW    = plstore_pkg::DATA_W;

    logic                 ex_vld_reg;
    logic                 ex_vld_next;
    logic [2:0]           ex_op_reg;
    logic [POS_W-1:0]     ex_pos_reg;
    logic [DW-1:0]        ex_data_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 out_vld_reg;
    logic                 out_vld_next;
    logic [DW-1:0]        out_val_reg;
    logic [1:0]           out_st_reg;
    logic [CNT_W-1:0]     out_len_reg;

    logic                 in_acc;
    logic                 ex_adv;
    logic                 pos_ok;
    logic                 full;
    logic                 empty;
    logic [1:0]           ex_status;
    logic                 take_val;
    logic [DW-1:0]        rd_any;
    logic [DW-1:0]        res_val;
    plstore_pkg::cell_cmd_t cmd;

    logic [DW-1:0]        cell_q  [CAP];
    logic [DW-1:0]        cell_rd [CAP];

    assign ex_adv        = ex_vld_reg && (!out_vld_reg || m_axis_tready);
    assign s_axis_tready = !ex_vld_reg || ex_adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign empty  = (count_reg == '0);
    assign full   = (count_reg == CNT_W'(CAP));
    assign pos_ok = (ex_pos_reg != '0) && (ex_pos_reg <= count_reg);

    // Decode the held item against the current length
    always_comb
    begin
        ex_status = plstore_pkg::ST_OK;
        take_val  = 1'b0;
        cmd.ins   = 1'b0;
        cmd.del   = 1'b0;
        cmd.wr    = 1'b0;
        cmd.sel   = IDX_W'(ex_pos_reg - POS_W'(1));
        cmd.data  = ex_data_reg;
        case (ex_op_reg)
            plstore_pkg::OP_READ:
            begin
                if (empty)
                    ex_status = plstore_pkg::ST_EMPTY;
                else if (!pos_ok)
                    ex_status = plstore_pkg::ST_POS;
                else
                    take_val = 1'b1;
            end
            plstore_pkg::OP_INS_AFTER:
            begin
                cmd.sel = IDX_W'(ex_pos_reg);
                if (ex_pos_reg > count_reg)
                    ex_status = plstore_pkg::ST_POS;
                else if (full)
                    ex_status = plstore_pkg::ST_FULL;
                else
                    cmd.ins = ex_adv;
            end
            plstore_pkg::OP_INS_BEFORE:
            begin
                if (!pos_ok)
                    ex_status = plstore_pkg::ST_POS;
                else if (full)
                    ex_status = plstore_pkg::ST_FULL;
                else
                    cmd.ins = ex_adv;
            end
            plstore_pkg::OP_DELETE:
            begin
                if (empty)
                    ex_status = plstore_pkg::ST_EMPTY;
                else if (!pos_ok)
                    ex_status = plstore_pkg::ST_POS;
                else
                begin
                    take_val = 1'b1;
                    cmd.del  = ex_adv;
                end
            end
            plstore_pkg::OP_CHANGE:
            begin
                if (!pos_ok)
                    ex_status = plstore_pkg::ST_POS;
                else
                begin
                    take_val = 1'b1;
                    cmd.wr   = ex_adv;
                end
            end
            default:
            begin
                ex_status = plstore_pkg::ST_OK;
            end
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAP; gi++)
        begin : g_cell
            logic [DW-1:0] left_q;
            logic [DW-1:0] right_q;
            if (gi == 0)
            begin : g_first
                assign left_q = '0;
            end
            else
            begin : g_mid_l
                assign left_q = cell_q[gi-1];
            end
            if (gi == CAP - 1)
            begin : g_last
                assign right_q = cell_q[gi];
            end
            else
            begin : g_mid_r
                assign right_q = cell_q[gi+1];
            end
            plstore_cell u_cell
            (
                .clk     (clk),
                .cmd     (cmd),
                .idx     (IDX_W'(gi)),
                .left_q  (left_q),
                .right_q (right_q),
                .q       (cell_q[gi]),
                .rd      (cell_rd[gi])
            );
        end
    endgenerate

    // Only the addressed cell drives a non-zero read value
    always_comb
    begin
        rd_any = '0;
        for (int i = 0; i < CAP; i++)
        begin
            rd_any = rd_any | cell_rd[i];
        end
    end

    assign res_val = take_val ? rd_any : '0;

    always_comb
    begin
        count_next = count_reg;
        if (cmd.ins)
            count_next = count_reg + CNT_W'(1);
        else if (cmd.del)
            count_next = count_reg - CNT_W'(1);
    end

    always_comb
    begin
        ex_vld_next = ex_vld_reg;
        if (in_acc)
            ex_vld_next = 1'b1;
        else if (ex_adv)
            ex_vld_next = 1'b0;
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (ex_adv)
            out_vld_next = 1'b1;
        else if (m_axis_tready)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            count_reg   <= '0;
        end
        else
        begin
            ex_vld_reg  <= ex_vld_next;
            out_vld_reg <= out_vld_next;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            ex_op_reg   <= s_axis_tdata[2:0];
            ex_pos_reg  <= s_axis_tdata[9:3];
            ex_data_reg <= s_axis_tdata[41:10];
        end
        if (ex_adv)
        begin
            out_val_reg <= res_val;
            out_st_reg  <= ex_status;
            out_len_reg <= count_next;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {7'd0, out_len_reg, out_st_reg, out_val_reg};

    `PLS_ASSERT_NOW(a_count_cap, clk, rst_n, 1'b1, count_reg <= CNT_W'(CAP))
    `PLS_ASSERT_NEXT(a_count_hold, clk, rst_n, !ex_adv, count_reg == $past(count_reg))
    `PLS_ASSERT_NEXT(a_err_len, clk, rst_n, ex_adv && (ex_status != plstore_pkg::ST_OK), count_reg == $past(count_reg))
    `PLS_ASSERT_NOW(a_stall_src, clk, rst_n, !s_axis_tready, ex_vld_reg && out_vld_reg)

endmodule
